@@ hdl/dual_pool_bump_allocator_macros.svh @@
// Assertion macros for the dual-pool bump allocator
`ifndef DUAL_POOL_BUMP_ALLOCATOR_MACROS_SVH
`define DUAL_POOL_BUMP_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define DPBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DPBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dpba_pkg.sv @@
// Package: types, codes and defaults for the dual-pool bump allocator
`timescale 1ns / 1ps

package dpba_pkg;

    localparam int DEF_MAX_TENSORS = 256;
    localparam int DEF_ALIGN_BYTES = 16;

    localparam logic [2:0] OP_INIT       = 3'd0;
    localparam logic [2:0] OP_ALLOC_FAST = 3'd1;
    localparam logic [2:0] OP_ALLOC_SLOW = 3'd2;
    localparam logic [2:0] OP_LOAD       = 3'd3;
    localparam logic [2:0] OP_SPILL      = 3'd4;
    localparam logic [2:0] OP_RESET_FAST = 3'd5;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OOM       = 2'd1;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;
    localparam logic [1:0] STATUS_NOT_SET   = 2'd3;

    localparam logic [2:0] CFG_TENSOR_COUNT   = 3'd0;
    localparam logic [2:0] CFG_FAST_BASE      = 3'd1;
    localparam logic [2:0] CFG_FAST_CAPACITY  = 3'd2;
    localparam logic [2:0] CFG_FAST_START_PAD = 3'd3;
    localparam logic [2:0] CFG_SLOW_BASE      = 3'd4;
    localparam logic [2:0] CFG_SLOW_CAPACITY  = 3'd5;
    localparam logic [2:0] CFG_SLOW_START_PAD = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EXEC
    } fsm_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] tensor_index;
        logic [31:0] byte_count;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] new_address;
        logic [31:0] source_address;
        logic [31:0] fast_in_use;
        logic [31:0] fast_peak_use;
    } result_t;

endpackage

@@ hdl/dual_pool_bump_allocator.sv @@
// Top level: dual-pool bump allocator with per-tensor address table
//
//   channel   | signals                                  | direction
//   ----------+------------------------------------------+----------
//   request   | start, busy, request                     | in
//   result    | done, result                             | out
//   config    | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// For a power-of-two ALIGN_BYTES the accept edge issues the table read, the next
// cycle executes and writes back, and done is high in the cycle after, when start
// is taken again. Other alignments first pass through ST_DIVIDE, which finds the
// size remainder by reciprocal multiply before ST_EXEC.
// Reset clears the state, counters, config registers and all valid bits; the table needs none.
// The result is shown for one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`include "dual_pool_bump_allocator_macros.svh"

module dual_pool_bump_allocator #(
    parameter int MAX_TENSORS = dpba_pkg::DEF_MAX_TENSORS,
    parameter int ALIGN_BYTES = dpba_pkg::DEF_ALIGN_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dpba_pkg::request_t request,
    output logic              done,
    output dpba_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam int  IDX_W      = (MAX_TENSORS > 1) ? $clog2(MAX_TENSORS) : 1;
    localparam int  ALIGN_L    = $clog2(ALIGN_BYTES);
    localparam int  REM_W      = ALIGN_L + 1;
    localparam bit  ALIGN_POW2 = ((ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0);
    localparam longint unsigned RECIP =
        ((64'd1 << (32 + ALIGN_L)) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
    localparam logic [32:0] RECIP_W = 33'(RECIP);

    dpba_pkg::fsm_t     state_reg, state_next;
    dpba_pkg::request_t req_reg;
    dpba_pkg::result_t  result_reg, result_next;
    logic               done_reg;

    logic [8:0]  tensor_count_reg;
    logic [31:0] fast_base_reg, fast_capacity_reg, slow_base_reg, slow_capacity_reg;
    logic [3:0]  fast_start_pad_reg, slow_start_pad_reg;

    logic [31:0] fast_used_reg, fast_used_next;
    logic [31:0] fast_floor_reg, fast_floor_next;
    logic [31:0] fast_peak_reg, fast_peak_next;
    logic [31:0] slow_used_reg, slow_used_next;
    logic [MAX_TENSORS-1:0] valid_reg, valid_next;

    logic [31:0] addr_mem [MAX_TENSORS];
    logic [31:0] rdata_reg;
    logic [IDX_W-1:0] rd_addr, idx_sel;
    logic        mem_we;
    logic [31:0] mem_wdata;

    logic [REM_W-1:0] rem_reg, rem_next, rem_val;
    logic [64:0]      prod_reg, prod_next;
    logic [31:0]      quot;
    logic             div_count_reg;

    logic accept, exec_en, div_en;

    logic        idx_ok, entry_ok, use_fast, fits;
    logic [31:0] pool_base, pool_cap, pool_used, alloc_addr, grown_used;
    logic [32:0] pad33, rounded33;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;
    assign idx_sel   = req_reg.tensor_index[IDX_W-1:0];
    assign rd_addr   = accept ? request.tensor_index[IDX_W-1:0] : idx_sel;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dpba_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ALIGN_POW2 ? dpba_pkg::ST_EXEC : dpba_pkg::ST_DIVIDE;
                end
            end
            dpba_pkg::ST_DIVIDE:
            begin
                if (div_count_reg)
                begin
                    state_next = dpba_pkg::ST_EXEC;
                end
            end
            dpba_pkg::ST_EXEC:
            begin
                state_next = dpba_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dpba_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy    = 1'b1;
        exec_en = 1'b0;
        div_en  = 1'b0;
        case (state_reg)
            dpba_pkg::ST_IDLE:   busy    = 1'b0;
            dpba_pkg::ST_DIVIDE: div_en  = 1'b1;
            dpba_pkg::ST_EXEC:   exec_en = 1'b1;
            default:             busy    = 1'b1;
        endcase
    end

    always_comb
    begin
        prod_next = {1'b0, {32'd0, req_reg.byte_count} * {32'd0, RECIP_W[31:0]}}
                  + (RECIP_W[32] ? {1'b0, req_reg.byte_count, 32'd0} : 65'd0);
        quot      = 32'(prod_reg >> (32 + ALIGN_L));
        rem_next  = REM_W'(req_reg.byte_count - 32'(quot * 32'(ALIGN_BYTES)));
    end

    always_comb
    begin
        if (ALIGN_POW2)
        begin
            rem_val = REM_W'(req_reg.byte_count & 32'(ALIGN_BYTES - 1));
        end
        else
        begin
            rem_val = rem_reg;
        end
        pad33     = (rem_val == '0) ? 33'd0 : 33'(ALIGN_BYTES) - 33'(rem_val);
        rounded33 = {1'b0, req_reg.byte_count} + pad33;

        idx_ok   = ({1'b0, req_reg.tensor_index} < {8'd0, tensor_count_reg})
                && ({1'b0, req_reg.tensor_index} < 17'(MAX_TENSORS));
        entry_ok = valid_reg[idx_sel];
        use_fast = (req_reg.operation == dpba_pkg::OP_ALLOC_FAST)
                || (req_reg.operation == dpba_pkg::OP_LOAD);

        pool_base = use_fast ? fast_base_reg : slow_base_reg;
        pool_cap  = use_fast ? fast_capacity_reg : slow_capacity_reg;
        pool_used = use_fast ? fast_used_reg : slow_used_reg;
        fits      = !rounded33[32] && !(pool_used > pool_cap)
                 && !(rounded33[31:0] > (pool_cap - pool_used));
        alloc_addr = pool_base + pool_used;
        grown_used = pool_used + rounded33[31:0];

        fast_used_next  = fast_used_reg;
        fast_floor_next = fast_floor_reg;
        fast_peak_next  = fast_peak_reg;
        slow_used_next  = slow_used_reg;
        valid_next      = valid_reg;
        mem_we          = 1'b0;
        mem_wdata       = alloc_addr;

        result_next                = '0;
        result_next.status         = dpba_pkg::STATUS_OK;

        case (req_reg.operation)
            dpba_pkg::OP_INIT:
            begin
                if ((32'(fast_start_pad_reg) > fast_capacity_reg)
                    || (32'(slow_start_pad_reg) > slow_capacity_reg))
                begin
                    result_next.status = dpba_pkg::STATUS_OOM;
                end
                else
                begin
                    fast_used_next  = 32'(fast_start_pad_reg);
                    fast_floor_next = 32'(fast_start_pad_reg);
                    fast_peak_next  = 32'(fast_start_pad_reg);
                    slow_used_next  = 32'(slow_start_pad_reg);
                    valid_next      = '0;
                end
            end
            dpba_pkg::OP_ALLOC_FAST, dpba_pkg::OP_ALLOC_SLOW,
            dpba_pkg::OP_LOAD, dpba_pkg::OP_SPILL:
            begin
                if (!idx_ok)
                begin
                    result_next.status = dpba_pkg::STATUS_BAD_INDEX;
                end
                else if (((req_reg.operation == dpba_pkg::OP_LOAD)
                           || (req_reg.operation == dpba_pkg::OP_SPILL)) && !entry_ok)
                begin
                    result_next.status = dpba_pkg::STATUS_NOT_SET;
                end
                else
                begin
                    if ((req_reg.operation == dpba_pkg::OP_LOAD)
                        || (req_reg.operation == dpba_pkg::OP_SPILL))
                    begin
                        result_next.source_address = rdata_reg;
                    end
                    if (!fits)
                    begin
                        result_next.status = dpba_pkg::STATUS_OOM;
                    end
                    else
                    begin
                        result_next.new_address = alloc_addr;
                        mem_we                  = 1'b1;
                        valid_next[idx_sel]     = 1'b1;
                        if (use_fast)
                        begin
                            fast_used_next = grown_used;
                            if (grown_used > fast_peak_reg)
                            begin
                                fast_peak_next = grown_used;
                            end
                        end
                        else
                        begin
                            slow_used_next = grown_used;
                        end
                    end
                end
            end
            dpba_pkg::OP_RESET_FAST:
            begin
                fast_used_next = fast_floor_reg;
            end
            default:
            begin
                result_next.status = dpba_pkg::STATUS_OK;
            end
        endcase

        result_next.fast_in_use   = fast_used_next;
        result_next.fast_peak_use = fast_peak_next;
    end

    always_ff @(posedge clk)
    begin
        if (exec_en && mem_we)
        begin
            addr_mem[idx_sel] <= mem_wdata;
        end
        rdata_reg <= addr_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (div_en && !div_count_reg)
        begin
            prod_reg <= prod_next;
        end
        if (exec_en)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= dpba_pkg::ST_IDLE;
            done_reg           <= 1'b0;
            rem_reg            <= '0;
            div_count_reg      <= 1'b0;
            tensor_count_reg   <= '0;
            fast_base_reg      <= '0;
            fast_capacity_reg  <= '0;
            fast_start_pad_reg <= '0;
            slow_base_reg      <= '0;
            slow_capacity_reg  <= '0;
            slow_start_pad_reg <= '0;
            fast_used_reg      <= '0;
            fast_floor_reg     <= '0;
            fast_peak_reg      <= '0;
            slow_used_reg      <= '0;
            valid_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec_en;
            if (accept)
            begin
                rem_reg       <= '0;
                div_count_reg <= 1'b0;
            end
            else if (div_en)
            begin
                div_count_reg <= 1'b1;
                if (div_count_reg)
                begin
                    rem_reg <= rem_next;
                end
            end
            if (exec_en)
            begin
                fast_used_reg  <= fast_used_next;
                fast_floor_reg <= fast_floor_next;
                fast_peak_reg  <= fast_peak_next;
                slow_used_reg  <= slow_used_next;
                valid_reg      <= valid_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dpba_pkg::CFG_TENSOR_COUNT:   tensor_count_reg   <= cfg_data[8:0];
                    dpba_pkg::CFG_FAST_BASE:      fast_base_reg      <= cfg_data;
                    dpba_pkg::CFG_FAST_CAPACITY:  fast_capacity_reg  <= cfg_data;
                    dpba_pkg::CFG_FAST_START_PAD: fast_start_pad_reg <= cfg_data[3:0];
                    dpba_pkg::CFG_SLOW_BASE:      slow_base_reg      <= cfg_data;
                    dpba_pkg::CFG_SLOW_CAPACITY:  slow_capacity_reg  <= cfg_data;
                    dpba_pkg::CFG_SLOW_START_PAD: slow_start_pad_reg <= cfg_data[3:0];
                    default:                      tensor_count_reg   <= tensor_count_reg;
                endcase
            end
        end
    end

    `DPBA_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy,
        "accepted request did not raise busy")
    `DPBA_ASSERT_NEXT(a_exec_done, clk, rst_n, exec_en, done && !busy,
        "execute cycle not followed by a single result strobe")
    `DPBA_ASSERT_NOW(a_peak_bound, clk, rst_n, 1'b1, fast_used_reg <= fast_peak_reg,
        "fast pool use above tracked peak")
    `DPBA_ASSERT_NOW(a_fail_no_addr, clk, rst_n,
        done && (result.status != dpba_pkg::STATUS_OK), result.new_address == 32'd0,
        "failed request reported an address")

endmodule
